>>> design/post_machine_step_engine_defines.svh
// ----------------------------------------------------------------------------
// Post machine step engine assertion macros
// Shared property forms for the checker that watches the engine's ports.
// ----------------------------------------------------------------------------
`ifndef POST_MACHINE_STEP_ENGINE_DEFINES_SVH
`define POST_MACHINE_STEP_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PMSE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define PMSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/pmse_pkg.sv
// ----------------------------------------------------------------------------
// Post machine step engine package
// Field widths, operation, command and status codes, and the structs passed
// between the engine's modules.
// ----------------------------------------------------------------------------
package pmse_pkg;

   // Fixed field widths of the request and response words.
   localparam int OP_W       = 3;
   localparam int ADDR_W     = 10;
   localparam int KIND_W     = 3;
   localparam int JUMP_W     = 9;
   localparam int PC_W       = 9;
   localparam int STAT_W     = 2;
   localparam int LEN_W      = 9;
   localparam int HEAD_OUT_W = 10;

   // Request operations.
   localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE   = 3'd1;
   localparam logic [OP_W-1:0] OP_READ    = 3'd2;
   localparam logic [OP_W-1:0] OP_HEAD    = 3'd3;
   localparam logic [OP_W-1:0] OP_INDEX   = 3'd4;
   localparam logic [OP_W-1:0] OP_STEP    = 3'd5;
   localparam logic [OP_W-1:0] OP_RESTART = 3'd6;

   // Program command kinds.
   localparam logic [KIND_W-1:0] CMD_LEFT   = 3'd0;
   localparam logic [KIND_W-1:0] CMD_RIGHT  = 3'd1;
   localparam logic [KIND_W-1:0] CMD_ZERO   = 3'd2;
   localparam logic [KIND_W-1:0] CMD_ONE    = 3'd3;
   localparam logic [KIND_W-1:0] CMD_BRANCH = 3'd4;
   localparam logic [KIND_W-1:0] CMD_END    = 3'd5;

   // Run status codes.
   localparam logic [STAT_W-1:0] ST_RUN = 2'd0;
   localparam logic [STAT_W-1:0] ST_OUT = 2'd1;
   localparam logic [STAT_W-1:0] ST_END = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD = 2'd3;

   // Head update selects.
   localparam logic [1:0] HSEL_HOLD = 2'd0;
   localparam logic [1:0] HSEL_ADDR = 2'd1;
   localparam logic [1:0] HSEL_DEC  = 2'd2;
   localparam logic [1:0] HSEL_INC  = 2'd3;

   // One program store entry.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [JUMP_W-1:0] jump_first;
      logic [JUMP_W-1:0] jump_second;
   } prog_cmd_type;

   // One request word as held in the execute stage.
   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ADDR_W-1:0] address;
      prog_cmd_type      cmd;
      logic              cell_value;
   } req_item_type;

   // Machine state seen by the execute logic.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PC_W-1:0]   pc;
      logic              head_bit;
      logic              pc_ok;
      logic              load_ok;
      logic              tpos_is_head;
   } arch_type;

   // Write-back decided by the execute logic.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PC_W-1:0]   pc;
      logic              prog_we;
      logic              tape_we;
      logic              tape_wdata;
      logic              tape_at_head;
      logic [1:0]        head_sel;
      logic              head_bit;
      logic              cell_bit;
   } upd_type;

endpackage

>>> design/pmse_prog_mem.sv
// ----------------------------------------------------------------------------
// Program store
// Single-port-write, single-port-read command memory with a registered read
// that holds its data until the next enabled read.
// ----------------------------------------------------------------------------
module pmse_prog_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [AW-1:0]         waddr,
   input  pmse_pkg::prog_cmd_type wdata,
   input  logic                  re,
   input  logic [AW-1:0]         raddr,
   output pmse_pkg::prog_cmd_type rdata
);
   import pmse_pkg::*;

   prog_cmd_type mem [DEPTH];
   prog_cmd_type rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/pmse_tape_mem.sv
// ----------------------------------------------------------------------------
// Tape memory
// One-bit tape with one write port and two registered read ports. After
// reset it sweeps every cell to zero, one cell per cycle, and reports busy.
// ----------------------------------------------------------------------------
module pmse_tape_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          reset,
   output logic          clear_busy,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic          wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr_a,
   input  logic [AW-1:0] raddr_b,
   output logic          rdata_a,
   output logic          rdata_b
);
   import pmse_pkg::*;

   logic          mem [DEPTH];
   logic          clr_busy_ff;
   logic          clr_busy_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic          rdata_a_ff;
   logic          rdata_b_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic          mem_wdata;

   // Clearing sweep counter.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // The sweep owns the write port while it runs.
   assign mem_we    = clr_busy_ff | we;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : waddr;
   assign mem_wdata = clr_busy_ff ? 1'b0 : wdata;

   // Memory array with registered reads.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (re) begin
         rdata_a_ff <= mem[raddr_a];
         rdata_b_ff <= mem[raddr_b];
      end
   end

   assign clear_busy = clr_busy_ff;
   assign rdata_a    = rdata_a_ff;
   assign rdata_b    = rdata_b_ff;

endmodule

>>> design/pmse_exec.sv
// ----------------------------------------------------------------------------
// Execute logic
// Decides the write-back of one word from the machine state and the data
// returned by the program and tape memories.
// ----------------------------------------------------------------------------
module pmse_exec (
   input  pmse_pkg::req_item_type item,
   input  pmse_pkg::arch_type     arch,
   input  pmse_pkg::prog_cmd_type prog_cmd,
   input  logic                   tape_bit_a,
   input  logic                   tape_bit_b,
   output pmse_pkg::upd_type      upd
);
   import pmse_pkg::*;

   logic [PC_W-1:0]   next_seq;
   logic [PC_W-1:0]   next_jump;
   logic [JUMP_W-1:0] branch_target;

   // Next index for ordinary commands and for a branch.
   assign next_seq      = arch.pc + 1'b1;
   assign next_jump     = (prog_cmd.jump_first != '0) ? prog_cmd.jump_first - 1'b1 : next_seq;
   assign branch_target = arch.head_bit ? prog_cmd.jump_second : prog_cmd.jump_first;

   always_comb begin
      upd              = '0;
      upd.status       = arch.status;
      upd.pc           = arch.pc;
      upd.tape_wdata   = item.cell_value;
      upd.head_sel     = HSEL_HOLD;
      upd.head_bit     = arch.head_bit;

      case (item.operation)
         OP_LOAD: begin
            upd.prog_we = arch.load_ok;
         end
         OP_WRITE: begin
            upd.tape_we = 1'b1;
            if (arch.tpos_is_head) begin
               upd.head_bit = item.cell_value;
            end
         end
         OP_HEAD: begin
            upd.head_sel = HSEL_ADDR;
            upd.head_bit = tape_bit_a;
         end
         OP_INDEX: begin
            upd.pc = item.address[PC_W-1:0];
         end
         OP_STEP: begin
            // A stopped machine ignores steps.
            if (arch.status == ST_RUN) begin
               if (!arch.pc_ok) begin
                  upd.status = ST_OUT;
               end else begin
                  case (prog_cmd.kind)
                     CMD_LEFT: begin
                        upd.head_sel = HSEL_DEC;
                        upd.head_bit = tape_bit_a;
                        upd.pc       = next_jump;
                     end
                     CMD_RIGHT: begin
                        upd.head_sel = HSEL_INC;
                        upd.head_bit = tape_bit_b;
                        upd.pc       = next_jump;
                     end
                     CMD_ZERO: begin
                        upd.tape_we      = 1'b1;
                        upd.tape_at_head = 1'b1;
                        upd.tape_wdata   = 1'b0;
                        upd.head_bit     = 1'b0;
                        upd.pc           = next_jump;
                     end
                     CMD_ONE: begin
                        upd.tape_we      = 1'b1;
                        upd.tape_at_head = 1'b1;
                        upd.tape_wdata   = 1'b1;
                        upd.head_bit     = 1'b1;
                        upd.pc           = next_jump;
                     end
                     CMD_BRANCH: begin
                        upd.pc = (branch_target != '0) ? branch_target - 1'b1 : next_seq;
                     end
                     CMD_END: begin
                        upd.status = ST_END;
                     end
                     default: begin
                        upd.status = ST_BAD;
                     end
                  endcase
               end
            end
         end
         OP_RESTART: begin
            upd.status = ST_RUN;
            upd.pc     = '0;
         end
         default: begin
         end
      endcase

      // A read reports the addressed cell, all else the cell under the head.
      upd.cell_bit = (item.operation == OP_READ) ? tape_bit_a : upd.head_bit;
   end

endmodule

>>> design/post_machine_step_engine.sv
// ----------------------------------------------------------------------------
// Post machine step engine
// Runs a program of tape commands one step per request word and serves
// program loads, tape reads and writes, head and index moves and restarts.
// ----------------------------------------------------------------------------
// Each request word is registered with its memory reads issued (program entry
// at the command index, tape cells on either side of the head or at the
// addressed cell); then, once the response register can take it, the result is
// decided and written back to the memories, the machine registers and the
// response register. The next word is held off until that write-back is done;
// a word may enter while the previous response still waits to be taken. The
// bit under the head is kept in a register beside the tape. After reset the
// tape is swept to zero, which holds off requests until the sweep is done;
// writes to program_length are taken at any time.
module post_machine_step_engine #(
   parameter int PROGRAM_DEPTH = 256,
   parameter int TAPE_LENGTH   = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pmse_pkg::LEN_W-1:0]        csr_program_length,
   // Request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pmse_pkg::OP_W-1:0]         req_operation,
   input  logic [pmse_pkg::ADDR_W-1:0]       req_address,
   input  logic [pmse_pkg::KIND_W-1:0]       req_command_type,
   input  logic [pmse_pkg::JUMP_W-1:0]       req_jump_first,
   input  logic [pmse_pkg::JUMP_W-1:0]       req_jump_second,
   input  logic                              req_cell_value,
   // Response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pmse_pkg::STAT_W-1:0]       rsp_status,
   output logic [pmse_pkg::PC_W-1:0]         rsp_command_index,
   output logic [pmse_pkg::HEAD_OUT_W-1:0]   rsp_head_position,
   output logic                              rsp_cell_bit
);
   import pmse_pkg::*;

   localparam int PA_W  = $clog2(PROGRAM_DEPTH);
   localparam int TA_W  = $clog2(TAPE_LENGTH);
   localparam int REM_W = ADDR_W + 17;

   // Reduce an address modulo the tape length by shifted subtraction.
   function automatic logic [ADDR_W-1:0] tape_wrap(input logic [ADDR_W-1:0] a);
      logic [REM_W-1:0] r;
      r = REM_W'(a);
      for (int k = ADDR_W - 1; k >= 0; k--) begin
         if (r >= (REM_W'(TAPE_LENGTH) << k)) begin
            r = r - (REM_W'(TAPE_LENGTH) << k);
         end
      end
      return r[ADDR_W-1:0];
   endfunction

   // Machine registers
   logic [STAT_W-1:0] status_ff, status_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [TA_W-1:0]   head_ff, head_in;
   logic              head_bit_ff, head_bit_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   // Execute stage
   logic              exe_valid_ff, exe_valid_in;
   req_item_type      exe_item_ff, exe_item_in;
   logic              exe_pc_ok_ff, exe_pc_ok_in;
   logic              exe_load_ok_ff, exe_load_ok_in;
   logic [TA_W-1:0]   exe_tpos_ff, exe_tpos_in;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [PC_W-1:0]       rsp_index_ff, rsp_index_in;
   logic [HEAD_OUT_W-1:0] rsp_head_ff, rsp_head_in;
   logic                  rsp_bit_ff, rsp_bit_in;

   logic            clear_busy;
   logic            req_accept;
   logic            exe_done;
   logic [TA_W-1:0] req_tpos;
   logic [TA_W-1:0] head_dec;
   logic [TA_W-1:0] head_inc;
   logic [TA_W-1:0] tape_raddr_a;
   logic [TA_W-1:0] tape_waddr;
   prog_cmd_type    prog_rdata;
   prog_cmd_type    req_cmd;
   req_item_type    req_item;
   logic            tape_rdata_a;
   logic            tape_rdata_b;
   arch_type        arch;
   upd_type         upd;

   // Handshakes: one word in the execute stage at a time.
   assign csr_ready  = 1'b1;
   assign req_stall  = clear_busy | exe_valid_ff;
   assign req_accept = req_valid & ~req_stall;
   assign exe_done   = exe_valid_ff & (~rsp_valid_ff | ~rsp_stall);

   // Tape positions around the head and at the request address.
   assign req_tpos     = TA_W'(tape_wrap(req_address));
   assign head_dec     = (head_ff == '0) ? TA_W'(TAPE_LENGTH - 1) : head_ff - 1'b1;
   assign head_inc     = (head_ff == TA_W'(TAPE_LENGTH - 1)) ? '0 : head_ff + 1'b1;
   assign tape_raddr_a = (req_operation == OP_STEP) ? head_dec : req_tpos;

   assign req_cmd = '{kind: req_command_type, jump_first: req_jump_first,
                      jump_second: req_jump_second};

   assign req_item = '{operation: req_operation, address: req_address,
                       cmd: req_cmd, cell_value: req_cell_value};

   // Issue: capture the word and the range checks taken from current state.
   always_comb begin
      exe_valid_in   = exe_valid_ff;
      if (req_accept) begin
         exe_valid_in = 1'b1;
      end else if (exe_done) begin
         exe_valid_in = 1'b0;
      end
      exe_item_in    = req_accept ? req_item : exe_item_ff;
      exe_pc_ok_in   = req_accept ? ((pc_ff < len_ff) && (int'(pc_ff) < PROGRAM_DEPTH))
                                  : exe_pc_ok_ff;
      exe_load_ok_in = req_accept ? (int'(req_address) < PROGRAM_DEPTH) : exe_load_ok_ff;
      exe_tpos_in    = req_accept ? req_tpos : exe_tpos_ff;
   end

   // Memories
   pmse_prog_mem #(
      .DEPTH (PROGRAM_DEPTH),
      .AW    (PA_W)
   ) u_prog_mem (
      .clock (clock),
      .we    (exe_done & upd.prog_we),
      .waddr (PA_W'(exe_item_ff.address)),
      .wdata (exe_item_ff.cmd),
      .re    (req_accept),
      .raddr (PA_W'(pc_ff)),
      .rdata (prog_rdata)
   );

   assign tape_waddr = upd.tape_at_head ? head_ff : exe_tpos_ff;

   pmse_tape_mem #(
      .DEPTH (TAPE_LENGTH),
      .AW    (TA_W)
   ) u_tape_mem (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .we         (exe_done & upd.tape_we),
      .waddr      (tape_waddr),
      .wdata      (upd.tape_wdata),
      .re         (req_accept),
      .raddr_a    (tape_raddr_a),
      .raddr_b    (head_inc),
      .rdata_a    (tape_rdata_a),
      .rdata_b    (tape_rdata_b)
   );

   // Execute
   assign arch = '{status: status_ff, pc: pc_ff, head_bit: head_bit_ff,
                   pc_ok: exe_pc_ok_ff, load_ok: exe_load_ok_ff,
                   tpos_is_head: (exe_tpos_ff == head_ff)};

   pmse_exec u_exec (
      .item       (exe_item_ff),
      .arch       (arch),
      .prog_cmd   (prog_rdata),
      .tape_bit_a (tape_rdata_a),
      .tape_bit_b (tape_rdata_b),
      .upd        (upd)
   );

   // Write-back of the machine registers.
   always_comb begin
      status_in   = status_ff;
      pc_in       = pc_ff;
      head_in     = head_ff;
      head_bit_in = head_bit_ff;
      len_in      = (csr_valid && csr_ready) ? csr_program_length : len_ff;
      if (exe_done) begin
         status_in   = upd.status;
         pc_in       = upd.pc;
         head_bit_in = upd.head_bit;
         case (upd.head_sel)
            HSEL_ADDR: head_in = exe_tpos_ff;
            HSEL_DEC:  head_in = head_dec;
            HSEL_INC:  head_in = head_inc;
            default:   head_in = head_ff;
         endcase
      end
   end

   // Response register loads when the execute stage finishes.
   always_comb begin
      rsp_valid_in  = exe_done | (rsp_valid_ff & rsp_stall);
      rsp_status_in = exe_done ? status_in : rsp_status_ff;
      rsp_index_in  = exe_done ? pc_in : rsp_index_ff;
      rsp_head_in   = exe_done ? HEAD_OUT_W'(head_in) : rsp_head_ff;
      rsp_bit_in    = exe_done ? upd.cell_bit : rsp_bit_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= ST_RUN;
         pc_ff        <= '0;
         head_ff      <= '0;
         head_bit_ff  <= 1'b0;
         len_ff       <= '0;
         exe_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         status_ff    <= status_in;
         pc_ff        <= pc_in;
         head_ff      <= head_in;
         head_bit_ff  <= head_bit_in;
         len_ff       <= len_in;
         exe_valid_ff <= exe_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      exe_item_ff    <= exe_item_in;
      exe_pc_ok_ff   <= exe_pc_ok_in;
      exe_load_ok_ff <= exe_load_ok_in;
      exe_tpos_ff    <= exe_tpos_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_head_ff    <= rsp_head_in;
      rsp_bit_ff     <= rsp_bit_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_command_index = rsp_index_ff;
   assign rsp_head_position = rsp_head_ff;
   assign rsp_cell_bit      = rsp_bit_ff;

endmodule

>>> design/pmse_checker.sv
// ----------------------------------------------------------------------------
// Post machine step engine checker
// Port-level properties of the engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "post_machine_step_engine_defines.svh"

module pmse_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [pmse_pkg::STAT_W-1:0]       rsp_status,
   input logic [pmse_pkg::PC_W-1:0]         rsp_command_index,
   input logic [pmse_pkg::HEAD_OUT_W-1:0]   rsp_head_position,
   input logic                              rsp_cell_bit
);
   import pmse_pkg::*;

   // A stalled response word stays valid and unchanged.
   `PMSE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_command_index) && $stable(rsp_head_position) && $stable(rsp_cell_bit), "response changed while stalled")

   // Only one word is in execution: an accepted request blocks the next cycle.
   `PMSE_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "request accepted while a word is executing")

   // The tape sweep after reset holds off requests.
   `PMSE_ASSERT_NEXT(a_clear_after_reset, clock, 1'b0, reset, req_stall, "request taken during tape clear")

   // A fresh response follows an accepted request, through the execute stage and the response register.
   `PMSE_ASSERT_IMPLY(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "response without a matching request")

endmodule

bind post_machine_step_engine pmse_checker u_pmse_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_command_index (rsp_command_index),
   .rsp_head_position (rsp_head_position),
   .rsp_cell_bit      (rsp_cell_bit)
);
